### sv/hcbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hcbd_pkg;

   localparam int unsigned REQ_TYPE_W = 2;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned COUNT_W    = 32;
   localparam int unsigned DIGIT_W    = 4;

   localparam logic [COUNT_W-1:0] CAPACITY_RESET = 32'd4096;

   localparam logic [BYTE_W-1:0] CHAR_0  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_9  = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_LA = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_LF_HEX = 8'h66;
   localparam logic [BYTE_W-1:0] CHAR_UA = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UF = 8'h46;
   localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_NL = 8'h0A;
   localparam logic [BYTE_W-1:0] HEX_ALPHA_BASE = 8'd10;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_BYTE    = 2'd0,
      REQ_END     = 2'd1,
      REQ_RESTART = 2'd2,
      REQ_UNUSED  = 2'd3
   } req_code_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_BYTE     = 2'd0,
      KIND_COMPLETE = 2'd1,
      KIND_OVERFLOW = 2'd2,
      KIND_EARLY    = 2'd3
   } kind_code_type;

   typedef enum logic [6:0] {
      MODE_SIZE   = 7'b0000001,
      MODE_EXT    = 7'b0000010,
      MODE_DATA   = 7'b0000100,
      MODE_POST   = 7'b0001000,
      MODE_POSTCR = 7'b0010000,
      MODE_DONE   = 7'b0100000,
      MODE_HALT   = 7'b1000000
   } mode_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [BYTE_W-1:0]     data_byte;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0]  result_kind;
      logic [BYTE_W-1:0]  body_byte;
      logic [COUNT_W-1:0] body_length;
   } rsp_item_type;

   typedef struct packed {
      logic is_hex;
      logic [DIGIT_W-1:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [BYTE_W-1:0] c);
      hex_digit_type d;
      logic [BYTE_W-1:0] v;
      d = '0;
      v = '0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         d.is_hex = 1'b1;
         v = c - CHAR_0;
      end else if (c >= CHAR_LA && c <= CHAR_LF_HEX) begin
         d.is_hex = 1'b1;
         v = c - CHAR_LA + HEX_ALPHA_BASE;
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         d.is_hex = 1'b1;
         v = c - CHAR_UA + HEX_ALPHA_BASE;
      end
      d.value = v[DIGIT_W-1:0];
      return d;
   endfunction

endpackage

`default_nettype wire

### sv/hcbd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hcbd_req_if;
   import hcbd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [BYTE_W-1:0]     data_byte;

   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface hcbd_rsp_if;
   import hcbd_pkg::*;
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  result_kind;
   logic [BYTE_W-1:0]  body_byte;
   logic [COUNT_W-1:0] body_length;

   modport source (output valid, output result_kind, output body_byte, output body_length,
                   input ready);
   modport sink   (input valid, input result_kind, input body_byte, input body_length,
                   output ready);
endinterface

`default_nettype wire

### sv/hcbd_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_in_reg (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  hcbd_pkg::req_item_type req_item,
   input  wire                  out_room,
   output logic                 item_fire,
   output hcbd_pkg::req_item_type item
);
   import hcbd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         accept;

   assign item_fire = valid_ff && out_room;
   assign req_ready = !valid_ff || item_fire;
   assign accept    = req_valid && req_ready;
   assign item      = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (item_fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

endmodule

`default_nettype wire

### sv/hcbd_step.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_step (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       item_fire,
   input  hcbd_pkg::req_item_type    item,
   input  wire [hcbd_pkg::COUNT_W-1:0] capacity,
   output logic                      res_hit,
   output hcbd_pkg::rsp_item_type    res
);
   import hcbd_pkg::*;

   mode_type           mode_ff, mode_in;
   logic [COUNT_W-1:0] chunk_ff, chunk_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic [COUNT_W-1:0] dec_ff, dec_in;
   logic [COUNT_W-1:0] raw_ff, raw_in;
   logic [COUNT_W-1:0] base;
   logic               do_size;
   logic               do_end;
   logic               is_nl;
   logic               is_cr;
   logic               active;
   hex_digit_type      digit;

   assign digit  = hex_decode(item.data_byte);
   assign is_nl  = (item.data_byte == CHAR_NL);
   assign is_cr  = (item.data_byte == CHAR_CR);
   assign active = (mode_ff != MODE_DONE) && (mode_ff != MODE_HALT);

   always_comb begin
      mode_in  = mode_ff;
      chunk_in = chunk_ff;
      left_in  = left_ff;
      dec_in   = dec_ff;
      raw_in   = raw_ff;
      base     = chunk_ff;
      do_size  = 1'b0;
      do_end   = 1'b0;
      res_hit  = 1'b0;
      res      = '0;
      unique case (item.req_type)
         REQ_BYTE: begin
            if (active) begin
               if (raw_ff >= capacity) begin
                  mode_in         = MODE_HALT;
                  res_hit         = 1'b1;
                  res.result_kind = KIND_OVERFLOW;
                  res.body_length = dec_ff;
               end else begin
                  raw_in = raw_ff + 1'b1;
                  unique case (mode_ff)
                     MODE_SIZE: begin
                        do_size = 1'b1;
                     end
                     MODE_EXT: begin
                        do_end = is_nl;
                     end
                     MODE_DATA: begin
                        dec_in  = dec_ff + 1'b1;
                        left_in = left_ff - 1'b1;
                        if (left_ff == COUNT_W'(1)) begin
                           mode_in = MODE_POST;
                        end
                        res_hit         = 1'b1;
                        res.result_kind = KIND_BYTE;
                        res.body_byte   = item.data_byte;
                        res.body_length = dec_ff + 1'b1;
                     end
                     MODE_POST: begin
                        if (is_cr) begin
                           mode_in = MODE_POSTCR;
                        end else begin
                           chunk_in = '0;
                           mode_in  = MODE_SIZE;
                           base     = '0;
                           do_size  = !is_nl;
                        end
                     end
                     MODE_POSTCR: begin
                        chunk_in = '0;
                        mode_in  = MODE_SIZE;
                        base     = '0;
                        do_size  = !is_nl;
                     end
                     default: begin
                        mode_in = MODE_HALT;
                     end
                  endcase
               end
            end
         end
         REQ_END: begin
            if (active) begin
               mode_in         = MODE_HALT;
               res_hit         = 1'b1;
               res.result_kind = KIND_EARLY;
               res.body_length = dec_ff;
            end
         end
         REQ_RESTART: begin
            mode_in  = MODE_SIZE;
            chunk_in = '0;
            left_in  = '0;
            dec_in   = '0;
            raw_in   = '0;
         end
         default: begin
         end
      endcase

      if (do_size) begin
         if (digit.is_hex) begin
            chunk_in = {base[COUNT_W-DIGIT_W-1:0], digit.value};
            mode_in  = MODE_SIZE;
         end else if (is_nl) begin
            do_end = 1'b1;
         end else begin
            mode_in = MODE_EXT;
         end
      end

      if (do_end) begin
         if (base == '0) begin
            mode_in         = MODE_DONE;
            res_hit         = 1'b1;
            res.result_kind = KIND_COMPLETE;
            res.body_length = dec_ff;
         end else begin
            left_in = base;
            mode_in = MODE_DATA;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SIZE;
         chunk_ff <= '0;
         left_ff  <= '0;
         dec_ff   <= '0;
         raw_ff   <= '0;
      end else if (item_fire) begin
         mode_ff  <= mode_in;
         chunk_ff <= chunk_in;
         left_ff  <= left_in;
         dec_ff   <= dec_in;
         raw_ff   <= raw_in;
      end
   end

endmodule

`default_nettype wire

### sv/hcbd_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_out_reg (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    load,
   input  hcbd_pkg::rsp_item_type res,
   output logic                   out_room,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output hcbd_pkg::rsp_item_type rsp_item
);
   import hcbd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign out_room  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= res;
      end
   end

endmodule

`default_nettype wire

### sv/http_chunked_body_decoder.sv
// Chunked HTTP body decoder, one raw byte per request.
// req_bus (valid/ready): req_type 0 carries data_byte, 1 marks end of stream,
// 2 restarts the body. rsp_bus (valid/ready) returns zero or one result per
// request: a decoded body byte, body complete with its length, raw byte budget
// overflow, or early end of stream. Overflow and early end halt decoding
// until a restart; trailer bytes after completion give nothing.
// csr_wr_en/csr_wr_data set the raw byte budget of one body (reset 4096);
// write it only while the block is idle.
// A request is held in the input register, then decoded into the result
// register, which drives rsp_bus.
// Throughput: one request per cycle while the result register is not
// stalled by rsp_ready; the parser state updates between the two registers.
// Reset clears the valid flags of both registers and the parser state and
// sets the budget back to 4096.
// When rsp_ready is low with a result held, the input register keeps its
// request and req_ready drops once it is full; no result is lost.
`timescale 1ns / 1ps
`default_nettype none

module http_chunked_body_decoder (
   input  wire                         clock,
   input  wire                         reset,
   hcbd_req_if.sink                    req_bus,
   hcbd_rsp_if.source                  rsp_bus,
   input  wire                         csr_wr_en,
   input  wire [hcbd_pkg::COUNT_W-1:0] csr_wr_data
);
   import hcbd_pkg::*;

   logic [COUNT_W-1:0] capacity_ff;
   req_item_type       req_item;
   req_item_type       item;
   rsp_item_type       res;
   rsp_item_type       rsp_item;
   logic               item_fire;
   logic               out_room;
   logic               res_hit;
   logic               rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   assign req_item.req_type  = req_bus.req_type;
   assign req_item.data_byte = req_bus.data_byte;

   hcbd_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .req_item  (req_item),
      .out_room  (out_room),
      .item_fire (item_fire),
      .item      (item)
   );

   hcbd_step u_step (
      .clock     (clock),
      .reset     (reset),
      .item_fire (item_fire),
      .item      (item),
      .capacity  (capacity_ff),
      .res_hit   (res_hit),
      .res       (res)
   );

   hcbd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (item_fire && res_hit),
      .res       (res),
      .out_room  (out_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_bus.valid       = rsp_valid;
   assign rsp_bus.result_kind = rsp_item.result_kind;
   assign rsp_bus.body_byte   = rsp_item.body_byte;
   assign rsp_bus.body_length = rsp_item.body_length;

endmodule

`default_nettype wire

### sv/hcbd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         req_ready,
   input wire                         rsp_valid,
   input wire                         rsp_ready,
   input wire [hcbd_pkg::KIND_W-1:0]  result_kind,
   input wire [hcbd_pkg::BYTE_W-1:0]  body_byte,
   input wire [hcbd_pkg::COUNT_W-1:0] body_length
);
   import hcbd_pkg::*;

   // a held result does not change while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_kind)
         && $stable(body_byte) && $stable(body_length))
      else $error("rsp changed while stalled");

   // only body bytes carry data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (result_kind != KIND_BYTE) |-> body_byte == '0)
      else $error("non-data rsp with nonzero byte");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // with the result register empty the block always takes a request
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty result register");

   // a body byte never reports a zero length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (result_kind == KIND_BYTE) |-> body_length != '0)
      else $error("body byte with zero length");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .result_kind (rsp_bus.result_kind),
   .body_byte   (rsp_bus.body_byte),
   .body_length (rsp_bus.body_length)
);

`default_nettype wire

### bench/tb_http_chunked_body_decoder.sv
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder;
   import hcbd_pkg::*;

   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 4;
   localparam int IDLE_LIMIT    = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]  csr_wr_data = '0;

   hcbd_req_if req_bus();
   hcbd_rsp_if rsp_bus();

   http_chunked_body_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   req_item_type request_q[$];
   rsp_item_type decoded_q[$];
   int queued_count = 0;
   int accepted_count = 0;
   int mismatch_count = 0;
   int send_gap_pct = 14;
   int recv_stall_pct = 53;
   int hold_token = 0;

   // decoder model state
   mode_type           body_mode = MODE_SIZE;
   logic [COUNT_W-1:0] size_acc = '0;
   logic [COUNT_W-1:0] left_in_chunk = '0;
   logic [COUNT_W-1:0] decoded_total = '0;
   logic [COUNT_W-1:0] raw_total = '0;
   logic [COUNT_W-1:0] budget = CAPACITY_RESET;

   function automatic bit hex_value(input logic [BYTE_W-1:0] c, output logic [3:0] v);
      v = '0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         v = 4'(c - CHAR_0);
      end else if (c >= CHAR_LA && c <= CHAR_LF_HEX) begin
         v = 4'(c - CHAR_LA + HEX_ALPHA_BASE);
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         v = 4'(c - CHAR_UA + HEX_ALPHA_BASE);
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit end_of_size_line(output rsp_item_type rsp);
      rsp = '0;
      if (size_acc == '0) begin
         body_mode = MODE_DONE;
         rsp.result_kind = KIND_COMPLETE;
         rsp.body_length = decoded_total;
         return 1'b1;
      end
      left_in_chunk = size_acc;
      body_mode = MODE_DATA;
      return 1'b0;
   endfunction

   function automatic bit size_char(input logic [BYTE_W-1:0] c, output rsp_item_type rsp);
      logic [3:0] v;
      rsp = '0;
      if (hex_value(c, v)) begin
         size_acc = {size_acc[COUNT_W-5:0], v};
         return 1'b0;
      end
      if (c == CHAR_NL) return end_of_size_line(rsp);
      body_mode = MODE_EXT;
      return 1'b0;
   endfunction

   function automatic bit predict_decode(input req_item_type r, output rsp_item_type rsp);
      logic [BYTE_W-1:0] c;
      rsp = '0;
      c = r.data_byte;
      case (r.req_type)
         REQ_BYTE: begin
            if (body_mode == MODE_DONE || body_mode == MODE_HALT) return 1'b0;
            if (raw_total >= budget) begin
               body_mode = MODE_HALT;
               rsp.result_kind = KIND_OVERFLOW;
               rsp.body_length = decoded_total;
               return 1'b1;
            end
            raw_total++;
            case (body_mode)
               MODE_SIZE: return size_char(c, rsp);
               MODE_EXT: begin
                  if (c == CHAR_NL) return end_of_size_line(rsp);
                  return 1'b0;
               end
               MODE_DATA: begin
                  decoded_total++;
                  left_in_chunk--;
                  if (left_in_chunk == '0) body_mode = MODE_POST;
                  rsp.result_kind = KIND_BYTE;
                  rsp.body_byte = c;
                  rsp.body_length = decoded_total;
                  return 1'b1;
               end
               MODE_POST, MODE_POSTCR: begin
                  if (body_mode == MODE_POST && c == CHAR_CR) begin
                     body_mode = MODE_POSTCR;
                     return 1'b0;
                  end
                  size_acc = '0;
                  body_mode = MODE_SIZE;
                  if (c == CHAR_NL) return 1'b0;
                  return size_char(c, rsp);
               end
               default: begin
                  body_mode = MODE_HALT;
                  return 1'b0;
               end
            endcase
         end
         REQ_END: begin
            if (body_mode == MODE_DONE || body_mode == MODE_HALT) return 1'b0;
            body_mode = MODE_HALT;
            rsp.result_kind = KIND_EARLY;
            rsp.body_length = decoded_total;
            return 1'b1;
         end
         REQ_RESTART: begin
            body_mode = MODE_SIZE;
            size_acc = '0;
            left_in_chunk = '0;
            decoded_total = '0;
            raw_total = '0;
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin : driver
      req_item_type taken;
      req_item_type next_req;
      rsp_item_type predicted;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            taken.req_type = req_bus.req_type;
            taken.data_byte = req_bus.data_byte;
            if (predict_decode(taken, predicted)) decoded_q.push_back(predicted);
            accepted_count++;
         end
         if (req_bus.valid && !req_bus.ready) begin
            // offered request stays on the bus
         end else if (request_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            next_req = request_q.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.req_type <= next_req.req_type;
            req_bus.data_byte <= next_req.data_byte;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : monitor
      rsp_item_type want;
      int hold_seen;
      int hold_left;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_seen = hold_token;
         hold_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (decoded_q.size() == 0) begin
               $display("%0t: unexpected result: expected none, got kind %0d byte %02h len %0d",
                        $realtime, rsp_bus.result_kind, rsp_bus.body_byte, rsp_bus.body_length);
               mismatch_count++;
            end else begin
               want = decoded_q.pop_front();
               if (rsp_bus.result_kind !== want.result_kind) begin
                  $display("%0t: result_kind mismatch: expected %0d, got %0d",
                           $realtime, want.result_kind, rsp_bus.result_kind);
                  mismatch_count++;
               end
               if (rsp_bus.body_byte !== want.body_byte) begin
                  $display("%0t: body_byte mismatch: expected %02h, got %02h",
                           $realtime, want.body_byte, rsp_bus.body_byte);
                  mismatch_count++;
               end
               if (rsp_bus.body_length !== want.body_length) begin
                  $display("%0t: body_length mismatch: expected %0d, got %0d",
                           $realtime, want.body_length, rsp_bus.body_length);
                  mismatch_count++;
               end
            end
         end
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("http_chunked_body_decoder test failed");
            $finish;
         end
      end
   end

   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom_range(255));
   endfunction

   task automatic push_req(input req_code_type t, input logic [BYTE_W-1:0] b);
      req_item_type r;
      r.req_type = t;
      r.data_byte = b;
      request_q.push_back(r);
      queued_count++;
   endtask

   task automatic push_text(input string s);
      foreach (s[i]) push_req(REQ_BYTE, s[i]);
   endtask

   task automatic push_crlf();
      push_req(REQ_BYTE, CHAR_CR);
      push_req(REQ_BYTE, CHAR_NL);
   endtask

   task automatic push_size(input logic [COUNT_W-1:0] n, input int lead_zeros);
      string s;
      logic [BYTE_W-1:0] ch;
      s = $sformatf("%0h", n);
      repeat (lead_zeros) push_req(REQ_BYTE, CHAR_0);
      foreach (s[i]) begin
         ch = s[i];
         if (ch >= CHAR_LA && $urandom_range(1)) ch = ch - (CHAR_LA - CHAR_UA);
         push_req(REQ_BYTE, ch);
      end
   endtask

   task automatic push_ext();
      logic [BYTE_W-1:0] b;
      push_text(";");
      repeat ($urandom_range(4)) begin
         do b = rand_byte(); while (b == CHAR_NL);
         push_req(REQ_BYTE, b);
      end
   endtask

   task automatic push_size_end();
      case ($urandom_range(3))
         0: push_req(REQ_BYTE, CHAR_NL);
         1: begin
            push_ext();
            push_crlf();
         end
         2: begin
            push_ext();
            push_req(REQ_BYTE, CHAR_NL);
         end
         default: push_crlf();
      endcase
   endtask

   task automatic push_data_end();
      case ($urandom_range(5))
         0: push_req(REQ_BYTE, CHAR_NL);
         1: push_req(REQ_BYTE, CHAR_CR);
         2: begin
         end
         default: push_crlf();
      endcase
   endtask

   task automatic push_body(input int max_chunk);
      int n;
      repeat ($urandom_range(3)) begin
         n = $urandom_range(max_chunk, 1);
         push_size(n, ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0);
         push_size_end();
         repeat (n) push_req(REQ_BYTE, rand_byte());
         push_data_end();
      end
      push_size(0, $urandom_range(1));
      push_size_end();
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(5, 1)) push_req(REQ_BYTE, rand_byte());
         if ($urandom_range(1)) push_req(REQ_END, rand_byte());
      end
   endtask

   task automatic push_broken_body(input int max_chunk);
      int n;
      n = $urandom_range(max_chunk, 1);
      push_size(n, 0);
      if ($urandom_range(3) != 0) begin
         push_size_end();
         repeat ($urandom_range(n - 1)) push_req(REQ_BYTE, rand_byte());
      end
      if ($urandom_range(2) != 0) push_req(REQ_END, rand_byte());
   endtask

   task automatic push_noise();
      repeat ($urandom_range(6, 1)) begin
         push_req(req_code_type'($urandom_range(3)), rand_byte());
      end
   endtask

   task automatic random_traffic(input int n_items, input int max_chunk);
      int stop_at;
      stop_at = queued_count + n_items;
      while (queued_count < stop_at) begin
         case ($urandom_range(9))
            0: push_noise();
            1: begin
               push_req(REQ_RESTART, rand_byte());
               push_broken_body(max_chunk);
            end
            default: begin
               push_req(REQ_RESTART, rand_byte());
               push_body(max_chunk);
            end
         endcase
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (accepted_count != queued_count || decoded_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_budget(input logic [COUNT_W-1:0] v);
      wait_drained();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      budget = v;
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.req_type = '0;
      req_bus.data_byte = '0;
      rsp_bus.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // sender idles a little, receiver stalls often
      send_gap_pct = 14;
      recv_stall_pct = 53;
      write_budget(CAPACITY_RESET);
      push_req(REQ_UNUSED, 8'hFF);
      push_text("1;");
      push_req(REQ_BYTE, 8'hFF);
      push_req(REQ_BYTE, 8'h00);
      push_req(REQ_BYTE, CHAR_NL);
      push_req(REQ_BYTE, 8'hFF);
      push_crlf();
      push_text("2");
      push_req(REQ_BYTE, CHAR_NL);
      push_req(REQ_BYTE, 8'h00);
      push_req(REQ_BYTE, CHAR_NL);
      push_req(REQ_BYTE, CHAR_NL);
      push_text("3");
      push_crlf();
      push_text("fF9");
      push_req(REQ_BYTE, CHAR_CR);
      push_text("0");
      push_req(REQ_BYTE, CHAR_NL);
      push_req(REQ_END, 8'h00);
      push_text("A");
      push_req(REQ_RESTART, 8'h00);
      push_req(REQ_END, 8'hFF);
      push_text("5");
      push_req(REQ_RESTART, 8'hFF);
      wait_drained();

      hold_token++;
      push_req(REQ_RESTART, 8'h00);
      push_size(60, 0);
      push_crlf();
      repeat (60) push_req(REQ_BYTE, rand_byte());
      push_crlf();
      push_size(0, 0);
      push_crlf();
      random_traffic(300, 16);
      wait_drained();
      random_traffic(300, 16);

      send_gap_pct = 53;
      recv_stall_pct = 14;
      write_budget('1);
      push_req(REQ_RESTART, 8'h00);
      push_text("100000002");
      push_crlf();
      push_text("xy");
      push_crlf();
      push_text("0");
      push_crlf();
      push_req(REQ_RESTART, 8'h00);
      push_text("FFFFFFFF");
      push_req(REQ_BYTE, CHAR_NL);
      repeat (3) push_req(REQ_BYTE, rand_byte());
      push_req(REQ_END, 8'h00);
      random_traffic(500, 24);

      write_budget('0);
      push_req(REQ_RESTART, 8'h00);
      push_text("a");
      push_text("b");
      push_req(REQ_END, 8'h00);
      push_req(REQ_RESTART, 8'h00);
      push_req(REQ_END, 8'h00);
      random_traffic(40, 4);

      send_gap_pct = 0;
      recv_stall_pct = 0;
      write_budget(1);
      push_req(REQ_RESTART, 8'h00);
      push_text("0");
      push_req(REQ_BYTE, CHAR_NL);
      random_traffic(40, 4);
      repeat (3) begin
         write_budget($urandom_range(80, 8));
         random_traffic(220, 12);
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("http_chunked_body_decoder test passed");
      end else begin
         $display("http_chunked_body_decoder test failed");
      end
      $finish;
   end

endmodule

### filelist.f
sv/hcbd_pkg.sv
sv/hcbd_if.sv
sv/hcbd_in_reg.sv
sv/hcbd_step.sv
sv/hcbd_out_reg.sv
sv/http_chunked_body_decoder.sv
sv/hcbd_checker.sv
bench/tb_http_chunked_body_decoder.sv
